>>> sv/ppsb_pkg.sv
`timescale 1ns / 1ps
// Package for the ping-pong sample buffer: shared types, codes and widths.
// Used by every module of the block; depends on nothing.
package ppsb_pkg;

   localparam int HALF_LEN_DEFAULT    = 256;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int SAMPLE_W     = 8;
   localparam int REPORT_W     = 9;
   localparam int REQ_TDATA_W  = 8;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 24;
   localparam int RSP_TUSER_W  = 2;
   localparam int RSP_PAD_W    = RSP_TDATA_W - SAMPLE_W - 1 - REPORT_W;

   typedef enum logic [1:0] {
      OP_RX      = 2'd0,
      OP_OVERRUN = 2'd1,
      OP_TICK    = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2
   } act_type;

   typedef struct packed {
      act_type               act;
      logic [SAMPLE_W-1:0]   wr_byte;
      logic                  play_live;
      logic                  led;
      logic                  report_valid;
      logic [REPORT_W-1:0]   report_count;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

>>> sv/ppsb_front.sv
`timescale 1ns / 1ps
// Front end of the ping-pong sample buffer: accepts requests, keeps the
// fill/play bookkeeping and issues one store command per request.
// Depends on ppsb_pkg.
module ppsb_front #(
   parameter int HALF_LEN = ppsb_pkg::HALF_LEN_DEFAULT,
   parameter int ADDR_W   = $clog2(2 * HALF_LEN)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ppsb_pkg::REQ_TDATA_W-1:0] req_tdata,  // rx_byte[7:0]
   input  logic [ppsb_pkg::REQ_TUSER_W-1:0] req_tuser,  // opcode[1:0]
   input  logic                             queue_full,
   output logic                             push,
   output logic [ADDR_W+ppsb_pkg::CMD_W-1:0] push_data
);
   import ppsb_pkg::*;

   localparam int CNT_W = $clog2(HALF_LEN);
   localparam logic [CNT_W-1:0]    LAST_POS = CNT_W'(HALF_LEN - 1);
   localparam logic [REPORT_W-1:0] FULL_RPT = REPORT_W'(HALF_LEN);

   logic             fill_half_ff, fill_half_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   logic [CNT_W-1:0] play_pos_ff, play_pos_in;
   logic             led_ff, led_in;
   logic             swapped_ff, swapped_in;
   logic [31:0]      count_wide;
   logic [ADDR_W-1:0] addr;
   cmd_type          cmd;
   opcode_type       op;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign op         = opcode_type'(req_tuser);
   assign count_wide = 32'(fill_count_ff);
   assign push_data  = {addr, cmd};

   always_comb begin
      fill_half_in  = fill_half_ff;
      fill_count_in = fill_count_ff;
      play_pos_in   = play_pos_ff;
      led_in        = led_ff;
      swapped_in    = swapped_ff;
      addr          = '0;
      cmd           = '0;
      cmd.act       = ACT_NONE;
      if (push) begin
         unique case (op)
            OP_RX: begin
               addr = fill_half_ff ? ADDR_W'(HALF_LEN) + ADDR_W'(fill_count_ff)
                                   : ADDR_W'(fill_count_ff);
               cmd.act     = ACT_WRITE;
               cmd.wr_byte = req_tdata[SAMPLE_W-1:0];
               if (fill_count_ff == LAST_POS) begin
                  fill_half_in     = ~fill_half_ff;
                  fill_count_in    = '0;
                  swapped_in       = 1'b1;
                  cmd.report_valid = 1'b1;
                  cmd.report_count = FULL_RPT;
               end else begin
                  fill_count_in = fill_count_ff + 1'b1;
               end
            end
            OP_OVERRUN: begin
               cmd.report_valid = 1'b1;
               cmd.report_count = count_wide[REPORT_W-1:0];
               fill_count_in    = '0;
            end
            OP_TICK: begin
               addr = fill_half_ff ? ADDR_W'(play_pos_ff)
                                   : ADDR_W'(HALF_LEN) + ADDR_W'(play_pos_ff);
               cmd.act       = ACT_READ;
               cmd.play_live = swapped_ff;
               led_in        = ~led_ff;
               play_pos_in   = (play_pos_ff == LAST_POS) ? '0 : play_pos_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
      cmd.led = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_half_ff  <= 1'b0;
         fill_count_ff <= '0;
         play_pos_ff   <= '0;
         led_ff        <= 1'b0;
         swapped_ff    <= 1'b0;
      end else begin
         fill_half_ff  <= fill_half_in;
         fill_count_ff <= fill_count_in;
         play_pos_ff   <= play_pos_in;
         led_ff        <= led_in;
         swapped_ff    <= swapped_in;
      end
   end

   a_swapped_sticks: assert property (@(posedge clock) disable iff (reset)
      swapped_ff |=> swapped_ff)
      else $error("swap flag cleared without reset");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (count_wide < 32'(HALF_LEN)) && (32'(play_pos_ff) < 32'(HALF_LEN)))
      else $error("fill count or play position out of range");

endmodule

>>> sv/ppsb_queue.sv
`timescale 1ns / 1ps
// Command queue between front and back of the ping-pong sample buffer.
// Plain register FIFO; depends on ppsb_pkg for nothing but its defaults.
module ppsb_queue #(
   parameter int DEPTH  = ppsb_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int DATA_W = ppsb_pkg::CMD_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   output logic              head_valid,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data
);
   import ppsb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

>>> sv/ppsb_back.sv
`timescale 1ns / 1ps
// Back end of the ping-pong sample buffer: sample store and response stage.
// Takes commands from ppsb_queue; depends on ppsb_pkg.
module ppsb_back #(
   parameter int HALF_LEN = ppsb_pkg::HALF_LEN_DEFAULT,
   parameter int ADDR_W   = $clog2(2 * HALF_LEN)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  logic [ADDR_W+ppsb_pkg::CMD_W-1:0] head_data,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sample_out[7:0], led_on[8], report_count[17:9], zero pad[23:18]
   output logic [ppsb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // sample_valid[0], report_valid[1]
   output logic [ppsb_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import ppsb_pkg::*;

   localparam int STORE_DEPTH = 2 * HALF_LEN;

   logic [SAMPLE_W-1:0] store_ff [STORE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                out_valid_ff;
   cmd_type             out_cmd_ff;
   cmd_type             head_cmd;
   logic [ADDR_W-1:0]   head_addr;
   logic                advance;
   logic [SAMPLE_W-1:0] sample;

   assign head_cmd  = cmd_type'(head_data[CMD_W-1:0]);
   assign head_addr = head_data[ADDR_W+CMD_W-1:CMD_W];
   assign advance   = !out_valid_ff || rsp_tready;
   assign pop       = advance && head_valid;

   always_ff @(posedge clock) begin
      if (pop && (head_cmd.act == ACT_WRITE)) begin
         store_ff[head_addr] <= head_cmd.wr_byte;
      end
      if (pop && (head_cmd.act == ACT_READ)) begin
         rd_data_ff <= store_ff[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_cmd_ff <= head_cmd;
      end
   end

   assign sample = ((out_cmd_ff.act == ACT_READ) && out_cmd_ff.play_live) ? rd_data_ff
                                                                          : '0;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_cmd_ff.report_count, out_cmd_ff.led, sample};
   assign rsp_tuser  = {out_cmd_ff.report_valid, (out_cmd_ff.act == ACT_READ)};

endmodule

>>> sv/ping_pong_sample_buffer_unit.sv
`timescale 1ns / 1ps
// Ping-pong sample buffer: received bytes fill one half of a 2*HALF_LEN byte
// store while timer ticks play the other half; a full half swaps roles and
// reports its count, an overrun reports and drops the partial count. The
// block takes one request per cycle while req_tready is high and returns one
// response per request from its response register; the single store port
// carries one write or one read per cycle. A QUEUE_DEPTH entry command queue
// absorbs response stalls before req_tready drops. No clearing pass is
// needed after reset: ticks before the first swap return zero.
// Depends on ppsb_pkg, ppsb_front, ppsb_queue and ppsb_back.
module ping_pong_sample_buffer_unit #(
   parameter int HALF_LEN    = ppsb_pkg::HALF_LEN_DEFAULT,
   parameter int QUEUE_DEPTH = ppsb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ppsb_pkg::REQ_TDATA_W-1:0] req_tdata,  // rx_byte[7:0]
   input  logic [ppsb_pkg::REQ_TUSER_W-1:0] req_tuser,  // opcode[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sample_out[7:0], led_on[8], report_count[17:9], zero pad[23:18]
   output logic [ppsb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // sample_valid[0], report_valid[1]
   output logic [ppsb_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import ppsb_pkg::*;

   localparam int ADDR_W = $clog2(2 * HALF_LEN);
   localparam int QW     = ADDR_W + CMD_W;

   logic          queue_full;
   logic          push;
   logic [QW-1:0] push_data;
   logic          head_valid;
   logic          pop;
   logic [QW-1:0] head_data;

   ppsb_front #(
      .HALF_LEN (HALF_LEN),
      .ADDR_W   (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   ppsb_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .pop        (pop),
      .head_data  (head_data)
   );

   ppsb_back #(
      .HALF_LEN (HALF_LEN),
      .ADDR_W   (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for ping_pong_sample_buffer_unit: directed and random byte, overrun
// and tick requests with random gaps and stalls on both streams, checked against
// a predictor that shadows the two halves of the sample store. Depends on ppsb_pkg.
module tb;
   import ppsb_pkg::*;

   localparam int HALF_LEN = HALF_LEN_DEFAULT;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 700;

   typedef struct packed {
      logic                sample_valid;
      logic [SAMPLE_W-1:0] sample_out;
      logic                led_on;
      logic                report_valid;
      logic [REPORT_W-1:0] report_count;
   } playback_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // rx_byte[7:0]
   logic [REQ_TUSER_W-1:0] req_tuser = '0;  // opcode[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // sample_out[7:0], led_on[8], report_count[17:9], zero pad[23:18]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // sample_valid[0], report_valid[1]
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   logic [SAMPLE_W-1:0] shadow_store [0:2*HALF_LEN-1];
   bit                  shadow_fill_half = 1'b0;
   int                  shadow_fill_count = 0;
   int                  shadow_play_pos = 0;
   bit                  shadow_led = 1'b0;
   int                  swap_count = 0;

   playback_result_type expected_results [$];
   int  error_count = 0;
   int  counted_requests = 0;
   bit  steady_sender = 1'b0;
   int  stall_left = 0;
   int  calm_left = 0;

   ping_pong_sample_buffer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   function automatic playback_result_type predict_playback(input logic [1:0] opcode,
                                                            input logic [7:0] rx_byte);
      playback_result_type res;
      res = '0;
      case (opcode)
         OP_RX: begin
            shadow_store[int'(shadow_fill_half) * HALF_LEN + shadow_fill_count] = rx_byte;
            shadow_fill_count++;
            if (shadow_fill_count >= HALF_LEN) begin
               shadow_fill_half = ~shadow_fill_half;
               res.report_valid = 1'b1;
               res.report_count = REPORT_W'(shadow_fill_count);
               shadow_fill_count = 0;
               swap_count++;
            end
         end
         OP_OVERRUN: begin
            res.report_valid = 1'b1;
            res.report_count = REPORT_W'(shadow_fill_count);
            shadow_fill_count = 0;
         end
         OP_TICK: begin
            shadow_led = ~shadow_led;
            res.sample_valid = 1'b1;
            res.sample_out = shadow_store[(shadow_fill_half ? 0 : HALF_LEN) + shadow_play_pos];
            shadow_play_pos++;
            if (shadow_play_pos >= HALF_LEN) shadow_play_pos = 0;
         end
         default: ;
      endcase
      res.led_on = shadow_led;
      return res;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      playback_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("response with no request pending: tdata %h tuser %h", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("sample_valid", want.sample_valid, rsp_tuser[0]);
            check_field("sample_out", want.sample_out, rsp_tdata[7:0]);
            check_field("led_on", want.led_on, rsp_tdata[8]);
            check_field("report_valid", want.report_valid, rsp_tuser[1]);
            check_field("report_count", want.report_count, rsp_tdata[17:9]);
         end
      end
   end

   // stall the response stream at random, with calm stretches in between
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (calm_left > 0) begin
            calm_left <= calm_left - 1;
         end else if ($urandom_range(0, 199) == 0) begin
            calm_left <= $urandom_range(50, 300);
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
         end
      end
   end

   task automatic send_request(input logic [1:0] opcode, input logic [7:0] rx_byte);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= opcode;
      req_tdata <= rx_byte;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_playback(opcode, rx_byte));
      if (opcode != OP_UNUSED) counted_requests++;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_idle_playback();
      repeat (3) send_request(OP_TICK, 8'h00);
   endtask

   task automatic test_overrun_empty();
      send_request(OP_OVERRUN, 8'hFF);
   endtask

   task automatic test_byte_extremes();
      send_request(OP_RX, 8'h00);
      send_request(OP_RX, 8'hFF);
      send_request(OP_RX, 8'h55);
      send_request(OP_RX, 8'hAA);
      send_request(OP_RX, 8'h80);
      send_request(OP_RX, 8'h01);
      send_request(OP_OVERRUN, 8'h00);
      send_request(OP_TICK, 8'hFF);
   endtask

   task automatic test_unused_opcode();
      send_request(OP_UNUSED, 8'hFF);
      send_request(OP_UNUSED, 8'h00);
      send_request(OP_RX, 8'h7F);
      send_request(OP_UNUSED, 8'hA5);
      send_request(OP_OVERRUN, 8'h00);
   endtask

   // fill one whole half, then play from it
   task automatic test_full_swap();
      for (int i = 0; i < HALF_LEN; i++) begin
         send_request(OP_RX, 8'(i * 37 + 11));
         if (i % 16 == 0) send_request(OP_TICK, 8'h00);
      end
      repeat (4) send_request(OP_TICK, 8'h00);
   endtask

   // fill segments run until a swap; broken segments end early in an overrun
   task automatic test_random_traffic();
      int start_swaps;
      int seg_len;
      int roll;
      while (counted_requests < RANDOM_REQUESTS) begin
         steady_sender = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 60) begin
            start_swaps = swap_count;
            while ((swap_count == start_swaps) && (counted_requests < RANDOM_REQUESTS)) begin
               roll = $urandom_range(0, 99);
               if (roll < 65) send_request(OP_RX, 8'($urandom));
               else if (roll < 96) send_request(OP_TICK, 8'($urandom));
               else send_request(OP_UNUSED, 8'($urandom));
            end
         end else begin
            seg_len = $urandom_range(1, 40);
            repeat (seg_len) begin
               if ($urandom_range(0, 99) < 60) send_request(OP_RX, 8'($urandom));
               else send_request(OP_TICK, 8'($urandom));
            end
            send_request(OP_OVERRUN, 8'($urandom));
         end
         if ($urandom_range(0, 3) == 0) wait_drained();
      end
      steady_sender = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < 2 * HALF_LEN; i++) shadow_store[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_idle_playback();
      test_overrun_empty();
      test_byte_extremes();
      test_unused_opcode();
      test_full_swap();
      wait_drained();
      test_random_traffic();
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
sv/ppsb_pkg.sv
sv/ppsb_front.sv
sv/ppsb_queue.sv
sv/ppsb_back.sv
sv/ping_pong_sample_buffer_unit.sv
verif/tb.sv
